### rtl/sdns_pkg.sv
package sdns_pkg;

  localparam int IDX_W   = 12;
  localparam int FIELD_W = 40;
  localparam int COUNT_W = 13;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic DIR_HIGHER = 1'b0;
  localparam logic DIR_LOWER  = 1'b1;

  typedef enum logic [1:0] {
    STAT_EXACT    = 2'd0,
    STAT_NEIGHBOR = 2'd1,
    STAT_NONE     = 2'd2,
    STAT_WRITE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FETCH
  } state_t;

  typedef struct packed {
    logic               cmd;
    logic               direction;
    logic [FIELD_W-1:0] key;
    logic [IDX_W-1:0]   entry_index;
    logic [FIELD_W-1:0] entry_contents_offset;
    logic [FIELD_W-1:0] entry_descriptor_offset;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   hit_index;
    logic [FIELD_W-1:0] hit_id;
    logic [FIELD_W-1:0] hit_contents_offset;
    logic [FIELD_W-1:0] hit_descriptor_offset;
  } rsp_t;

endpackage

### rtl/sorted_directory_neighbor_search.sv
// Sorted directory with next-higher / next-lower lookup.
// Command channel: a word in req is taken at a rising edge with start high and
// busy low. cmd write stores id and both offsets at entry_index; cmd query
// binary-searches the first entry_count slots for req.key.
// Result channel: each word produces exactly one result word on rsp, marked by
// done for a single cycle. The receiver cannot stall; read rsp when done is high.
// Config: cfg_we writes cfg_data into entry_count; write it only while idle.
// Answers: a write answers in the cycle after acceptance and leaves busy low.
// A query against an empty table answers the same way. Otherwise busy stays
// high while the search runs over n = entry_count clipped to the depth:
// one probe per cycle through the single read port of the directory memory,
// then, if an entry is chosen, S_FETCH reads it and the result is registered.
// Reset clears entry_count, the sequencer and done. The directory memory is not
// cleared; entries must be written before they are searched.
module sorted_directory_neighbor_search #(
  parameter int DIR_DEPTH = 4096,
  parameter int ID_BITS = 40,
  parameter int OFFSET_BITS = 40
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  sdns_pkg::req_t               req,
  output logic                         done,
  output sdns_pkg::rsp_t               rsp,
  input  logic                         cfg_we,
  input  logic [sdns_pkg::COUNT_W-1:0] cfg_data
);

  import sdns_pkg::*;

  localparam int AW = $clog2(DIR_DEPTH);
  localparam int W = ID_BITS + 2 * OFFSET_BITS;

  logic [COUNT_W-1:0] entry_count;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [W-1:0]       ram_wdata;
  logic [W-1:0]       ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_data;
    end
  end

  sdns_ram #(
    .WIDTH(W),
    .DEPTH(DIR_DEPTH)
  ) u_dir (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  sdns_ctrl #(
    .DIR_DEPTH  (DIR_DEPTH),
    .ID_BITS    (ID_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .entry_count(entry_count),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_write_answer: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.cmd == CMD_WRITE |=> done && rsp.status == STAT_WRITE)
    else $error("write word not answered next cycle");

  a_query_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.cmd == CMD_QUERY |=> busy || (done && rsp.status == STAT_NONE))
    else $error("query word neither searched nor answered");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status == STAT_NONE || rsp.status == STAT_WRITE)
      |-> rsp.hit_index == '0 && rsp.hit_id == '0 && rsp.hit_contents_offset == '0)
    else $error("entry fields set on a result without an entry");

endmodule

### rtl/sdns_ram.sv
module sdns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/sdns_ctrl.sv
module sdns_ctrl #(
  parameter int DIR_DEPTH = 4096,
  parameter int ID_BITS = 40,
  parameter int OFFSET_BITS = 40,
  localparam int AW = $clog2(DIR_DEPTH),
  localparam int CW = $clog2(DIR_DEPTH + 1),
  localparam int W = ID_BITS + 2 * OFFSET_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  sdns_pkg::req_t                 req,
  output logic                           done,
  output sdns_pkg::rsp_t                 rsp,
  input  logic [sdns_pkg::COUNT_W-1:0]   entry_count,
  output logic                           ram_we,
  output logic [AW-1:0]                  ram_addr,
  output logic [W-1:0]                   ram_wdata,
  input  logic [W-1:0]                   ram_rdata
);

  import sdns_pkg::*;

  state_t             state, state_next;
  logic [ID_BITS-1:0] key_r, key_next;
  logic               dir_r, dir_next;
  logic [CW-1:0]      n_r, n_next;
  logic [CW-1:0]      lo, lo_next;
  logic [CW-1:0]      hi, hi_next;
  logic [CW-1:0]      lo_m1, lo_m1_next;
  logic [CW-1:0]      mid, mid_next;
  logic               eq, eq_next;
  status_t            hit_status, hit_status_next;
  logic [AW-1:0]      fetch_idx, fetch_idx_next;
  logic               done_next;
  rsp_t               rsp_next;

  logic [ID_BITS-1:0]     rd_id;
  logic [OFFSET_BITS-1:0] rd_coff;
  logic [OFFSET_BITS-1:0] rd_doff;
  logic                   lt;
  logic [CW-1:0]          lo_n, hi_n, lo_m1_n;
  logic                   eq_n;
  logic [CW:0]            sum;
  logic [CW-1:0]          mid_n;
  logic                   found;
  logic [CW-1:0]          n_in;
  logic                   wr_in_range;

  assign rd_id   = ram_rdata[W-1 -: ID_BITS];
  assign rd_coff = ram_rdata[2*OFFSET_BITS-1 -: OFFSET_BITS];
  assign rd_doff = ram_rdata[OFFSET_BITS-1:0];

  assign lt      = rd_id < key_r;
  assign lo_n    = lt ? mid + CW'(1) : lo;
  assign hi_n    = lt ? hi : mid;
  assign lo_m1_n = lt ? mid : lo_m1;
  assign eq_n    = lt ? eq : (rd_id == key_r);
  assign sum     = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n   = sum[CW:1];
  assign found   = lo_n < n_r;

  assign n_in = (32'(entry_count) > 32'(DIR_DEPTH)) ? CW'(DIR_DEPTH) : CW'(entry_count);
  assign wr_in_range = 32'(req.entry_index) < 32'(DIR_DEPTH);

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    key_next        = key_r;
    dir_next        = dir_r;
    n_next          = n_r;
    lo_next         = lo;
    hi_next         = hi;
    lo_m1_next      = lo_m1;
    mid_next        = mid;
    eq_next         = eq;
    hit_status_next = hit_status;
    fetch_idx_next  = fetch_idx;
    done_next       = 1'b0;
    rsp_next        = rsp;
    ram_we          = 1'b0;
    ram_addr        = mid[AW-1:0];
    ram_wdata       = {ID_BITS'(req.key), OFFSET_BITS'(req.entry_contents_offset),
                       OFFSET_BITS'(req.entry_descriptor_offset)};
    case (state)
      S_IDLE: begin
        if (start) begin
          if (req.cmd == CMD_WRITE) begin
            ram_we    = wr_in_range;
            ram_addr  = AW'(req.entry_index);
            done_next = 1'b1;
            rsp_next  = '0;
            rsp_next.status = STAT_WRITE;
          end else begin
            key_next   = ID_BITS'(req.key);
            dir_next   = req.direction;
            n_next     = n_in;
            lo_next    = '0;
            hi_next    = n_in;
            lo_m1_next = '0;
            eq_next    = 1'b0;
            mid_next   = n_in >> 1;
            ram_addr   = mid_next[AW-1:0];
            if (n_in == '0) begin
              done_next = 1'b1;
              rsp_next  = '0;
              rsp_next.status = STAT_NONE;
            end else begin
              state_next = S_SEARCH;
            end
          end
        end
      end
      S_SEARCH: begin
        lo_next    = lo_n;
        hi_next    = hi_n;
        lo_m1_next = lo_m1_n;
        eq_next    = eq_n;
        mid_next   = mid_n;
        if (lo_n < hi_n) begin
          ram_addr = mid_n[AW-1:0];
        end else if (found && (eq_n || dir_r == DIR_HIGHER)) begin
          fetch_idx_next  = lo_n[AW-1:0];
          hit_status_next = eq_n ? STAT_EXACT : STAT_NEIGHBOR;
          ram_addr        = lo_n[AW-1:0];
          state_next      = S_FETCH;
        end else if (dir_r == DIR_LOWER && lo_n != '0) begin
          fetch_idx_next  = lo_m1_n[AW-1:0];
          hit_status_next = STAT_NEIGHBOR;
          ram_addr        = lo_m1_n[AW-1:0];
          state_next      = S_FETCH;
        end else begin
          done_next  = 1'b1;
          rsp_next   = '0;
          rsp_next.status = STAT_NONE;
          state_next = S_IDLE;
        end
      end
      S_FETCH: begin
        ram_addr  = fetch_idx;
        done_next = 1'b1;
        rsp_next.status                = hit_status;
        rsp_next.hit_index             = IDX_W'(fetch_idx);
        rsp_next.hit_id                = FIELD_W'(rd_id);
        rsp_next.hit_contents_offset   = FIELD_W'(rd_coff);
        rsp_next.hit_descriptor_offset = FIELD_W'(rd_doff);
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    key_r      <= key_next;
    dir_r      <= dir_next;
    n_r        <= n_next;
    lo         <= lo_next;
    hi         <= hi_next;
    lo_m1      <= lo_m1_next;
    mid        <= mid_next;
    eq         <= eq_next;
    hit_status <= hit_status_next;
    fetch_idx  <= fetch_idx_next;
    rsp        <= rsp_next;
  end

endmodule
